FILE: rtl/core/sri_pkg.sv
// Shared types and constants for the segment/rectangle intersection pipeline.
package sri_pkg;

    localparam int COORD_BITS = 16;
    localparam int C1_BITS    = COORD_BITS + 1;
    localparam int OFS_BITS   = COORD_BITS + 2;
    localparam int PROD_BITS  = 2 * COORD_BITS + 3;
    localparam int SP_BITS    = 2 * COORD_BITS + 1;
    localparam int BP_BITS    = 2 * COORD_BITS + 2;

    // edge order: top, right, bottom, left
    localparam int EDGE_TOP = 0;
    localparam int EDGE_RGT = 1;
    localparam int EDGE_BOT = 2;
    localparam int EDGE_LFT = 3;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic signed [COORD_BITS-1:0] rect_x;
        logic signed [COORD_BITS-1:0] rect_y;
        logic        [COORD_BITS-2:0] rect_w;
        logic        [COORD_BITS-2:0] rect_h;
    } sri_query_t;

    typedef struct packed {
        logic                         hit;
        logic signed [COORD_BITS-1:0] hit_x;
        logic signed [COORD_BITS-1:0] hit_y;
    } sri_result_t;

    // products for the top, right, bottom and left edges
    typedef struct packed {
        logic signed [SP_BITS-1:0]    psh;
        logic signed [SP_BITS-1:0]    psv;
        logic signed [PROD_BITS-1:0]  pt_top;
        logic signed [PROD_BITS-1:0]  pt_rgt;
        logic signed [PROD_BITS-1:0]  pt_bot;
        logic signed [PROD_BITS-1:0]  pt_lft;
        logic signed [SP_BITS-1:0]    plo_h;
        logic signed [BP_BITS-1:0]    phi_h;
        logic signed [SP_BITS-1:0]    plo_v;
        logic signed [BP_BITS-1:0]    phi_v;
        logic        [COORD_BITS-1:0] fix_top;
        logic        [COORD_BITS-1:0] fix_rgt;
        logic        [COORD_BITS-1:0] fix_bot;
        logic        [COORD_BITS-1:0] fix_lft;
        logic        [COORD_BITS-1:0] dh;
        logic        [COORD_BITS-1:0] dv;
        logic        [3:0]            ua_ok;
    } sri_prod_t;

    // winning edge, handed to the divider
    typedef struct packed {
        logic                         hit;
        logic                         horiz;
        logic                         neg;
        logic        [COORD_BITS-1:0] fixed;
        logic        [PROD_BITS-1:0]  mag;
        logic        [COORD_BITS-1:0] d;
    } sri_div_t;

    typedef struct packed {
        logic                         hit;
        logic                         horiz;
        logic                         neg;
        logic        [COORD_BITS-1:0] fixed;
        logic        [PROD_BITS-1:0]  rem;
        logic        [COORD_BITS-1:0] d;
        logic        [COORD_BITS-1:0] q;
    } sri_dstage_t;

endpackage

FILE: rtl/core/segment_rect_intersect.sv
// Segment versus axis-aligned rectangle intersection, top level.
//
// Query channel (query_valid, query_stall, query): one segment and one
// rectangle per transaction. Result channel (result_valid, result_stall,
// result): one hit flag and hit point per query, in query order.
// Edges are tested top, right, bottom, left; the first hit edge wins and the
// hit point is truncated toward zero. No hit gives a zero point.
// Pipeline: 20 register stages (two setup and product stages, one edge-select
// stage, a 16-stage divider, one output register). Throughput: one query per
// cycle while the pipeline is not frozen by result_stall; the divider is fully
// pipelined with one quotient bit per stage.
// Reset clears all valid bits; the data registers are not reset.
// When result_stall is high while a result is valid the whole pipeline
// freezes and query_stall goes high; nothing is dropped or repeated, and
// bubbles in the pipeline are not squeezed out.
module segment_rect_intersect (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 query_valid,
    output logic                 query_stall,
    input  sri_pkg::sri_query_t  query,
    output logic                 result_valid,
    input  logic                 result_stall,
    output sri_pkg::sri_result_t result
);
    import sri_pkg::*;

    logic      en;
    logic      prod_vld, div_vld;
    sri_prod_t prod;
    sri_div_t  div;

    assign en          = !(result_valid && result_stall);
    assign query_stall = !en;

    sri_edge u_edge (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (query_valid),
        .query   (query),
        .out_vld (prod_vld),
        .prod    (prod)
    );

    sri_pick u_pick (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (prod_vld),
        .prod    (prod),
        .out_vld (div_vld),
        .div     (div)
    );

    sri_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (div_vld),
        .div     (div),
        .out_vld (result_valid),
        .result  (result)
    );

endmodule

FILE: rtl/core/sri_edge.sv
// Edge setup and cross-product stages (two register stages).
module sri_edge (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  sri_pkg::sri_query_t query,
    output logic               out_vld,
    output sri_pkg::sri_prod_t prod
);
    import sri_pkg::*;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] sx;
        logic signed [COORD_BITS-1:0] sy;
        logic signed [COORD_BITS-1:0] rx;
        logic signed [COORD_BITS-1:0] ry;
        logic signed [C1_BITS-1:0]    rxw;
        logic signed [C1_BITS-1:0]    ryh;
        logic signed [C1_BITS-1:0]    dx;
        logic signed [C1_BITS-1:0]    dy;
        logic        [COORD_BITS-1:0] dh;
        logic        [COORD_BITS-1:0] dv;
        logic signed [OFS_BITS-1:0]   t_top;
        logic signed [OFS_BITS-1:0]   t_rgt;
        logic signed [OFS_BITS-1:0]   t_bot;
        logic signed [OFS_BITS-1:0]   t_lft;
        logic        [3:0]            ua_ok;
    } sri_s1_t;

    sri_s1_t   s1_next, s1_reg;
    logic      s1_vld_reg;
    sri_prod_t prod_next, prod_reg;
    logic      prod_vld_reg;

    logic signed [C1_BITS-1:0]  dx, dy, adx, ady, rxw, ryh;
    logic signed [OFS_BITS-1:0] t_top, t_rgt, t_bot, t_lft;
    logic signed [OFS_BITS-1:0] n_top, n_rgt, n_bot, n_lft, dh_s, dv_s;
    logic signed [C1_BITS-1:0]  dh_m, dv_m;

    always_comb
    begin
        dx  = C1_BITS'($signed(query.end_x)) - C1_BITS'($signed(query.start_x));
        dy  = C1_BITS'($signed(query.end_y)) - C1_BITS'($signed(query.start_y));
        adx = dx[C1_BITS-1] ? -dx : dx;
        ady = dy[C1_BITS-1] ? -dy : dy;
        rxw = C1_BITS'($signed(query.rect_x)) + $signed({2'b00, query.rect_w});
        ryh = C1_BITS'($signed(query.rect_y)) + $signed({2'b00, query.rect_h});

        t_top = OFS_BITS'($signed(query.rect_y)) - OFS_BITS'($signed(query.start_y));
        t_bot = OFS_BITS'(ryh) - OFS_BITS'($signed(query.start_y));
        t_rgt = OFS_BITS'(rxw) - OFS_BITS'($signed(query.start_x));
        t_lft = OFS_BITS'($signed(query.rect_x)) - OFS_BITS'($signed(query.start_x));

        // sign-normalize so the divisor is positive
        n_top = dy[C1_BITS-1] ? -t_top : t_top;
        n_bot = dy[C1_BITS-1] ? -t_bot : t_bot;
        n_rgt = dx[C1_BITS-1] ? -t_rgt : t_rgt;
        n_lft = dx[C1_BITS-1] ? -t_lft : t_lft;

        dh_m = ady;
        dv_m = adx;
        dh_s = OFS_BITS'(ady);
        dv_s = OFS_BITS'(adx);

        s1_next.sx    = query.start_x;
        s1_next.sy    = query.start_y;
        s1_next.rx    = query.rect_x;
        s1_next.ry    = query.rect_y;
        s1_next.rxw   = rxw;
        s1_next.ryh   = ryh;
        s1_next.dx    = dx;
        s1_next.dy    = dy;
        s1_next.dh    = dh_m[COORD_BITS-1:0];
        s1_next.dv    = dv_m[COORD_BITS-1:0];
        s1_next.t_top = n_top;
        s1_next.t_rgt = n_rgt;
        s1_next.t_bot = n_bot;
        s1_next.t_lft = n_lft;
        // zero-length edges and parallel edges drop out here
        s1_next.ua_ok[EDGE_TOP] = (query.rect_w != '0) && (dy != '0)
                                  && !n_top[OFS_BITS-1] && (n_top <= dh_s);
        s1_next.ua_ok[EDGE_BOT] = (query.rect_w != '0) && (dy != '0)
                                  && !n_bot[OFS_BITS-1] && (n_bot <= dh_s);
        s1_next.ua_ok[EDGE_RGT] = (query.rect_h != '0) && (dx != '0)
                                  && !n_rgt[OFS_BITS-1] && (n_rgt <= dv_s);
        s1_next.ua_ok[EDGE_LFT] = (query.rect_h != '0) && (dx != '0)
                                  && !n_lft[OFS_BITS-1] && (n_lft <= dv_s);
    end

    logic signed [C1_BITS-1:0] dh1, dv1;

    always_comb
    begin
        dh1 = $signed({1'b0, s1_reg.dh});
        dv1 = $signed({1'b0, s1_reg.dv});
        prod_next.psh     = s1_reg.sx * dh1;
        prod_next.psv     = s1_reg.sy * dv1;
        prod_next.pt_top  = s1_reg.t_top * s1_reg.dx;
        prod_next.pt_bot  = s1_reg.t_bot * s1_reg.dx;
        prod_next.pt_rgt  = s1_reg.t_rgt * s1_reg.dy;
        prod_next.pt_lft  = s1_reg.t_lft * s1_reg.dy;
        prod_next.plo_h   = s1_reg.rx * dh1;
        prod_next.phi_h   = s1_reg.rxw * dh1;
        prod_next.plo_v   = s1_reg.ry * dv1;
        prod_next.phi_v   = s1_reg.ryh * dv1;
        prod_next.fix_top = s1_reg.ry;
        prod_next.fix_rgt = s1_reg.rxw[COORD_BITS-1:0];
        prod_next.fix_bot = s1_reg.ryh[COORD_BITS-1:0];
        prod_next.fix_lft = s1_reg.rx;
        prod_next.dh      = s1_reg.dh;
        prod_next.dv      = s1_reg.dv;
        prod_next.ua_ok   = s1_reg.ua_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg   <= in_vld;
            prod_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg   <= s1_next;
            prod_reg <= prod_next;
        end
    end

    assign out_vld = prod_vld_reg;
    assign prod    = prod_reg;

endmodule

FILE: rtl/core/sri_pick.sv
// Edge test against the rectangle span and first-hit selection (one stage).
module sri_pick (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  sri_pkg::sri_prod_t prod,
    output logic              out_vld,
    output sri_pkg::sri_div_t  div
);
    import sri_pkg::*;

    logic signed [PROD_BITS-1:0] n_top, n_rgt, n_bot, n_lft;
    logic signed [PROD_BITS-1:0] lo_h, hi_h, lo_v, hi_v, n_sel;
    logic [3:0] ok;
    sri_div_t   div_next, div_reg;
    logic       vld_reg;

    always_comb
    begin
        n_top = PROD_BITS'(prod.psh) + prod.pt_top;
        n_bot = PROD_BITS'(prod.psh) + prod.pt_bot;
        n_rgt = PROD_BITS'(prod.psv) + prod.pt_rgt;
        n_lft = PROD_BITS'(prod.psv) + prod.pt_lft;
        lo_h  = PROD_BITS'(prod.plo_h);
        hi_h  = PROD_BITS'(prod.phi_h);
        lo_v  = PROD_BITS'(prod.plo_v);
        hi_v  = PROD_BITS'(prod.phi_v);

        // exact hit coordinate times d must land inside the edge span
        ok[EDGE_TOP] = prod.ua_ok[EDGE_TOP] && (n_top >= lo_h) && (n_top <= hi_h);
        ok[EDGE_BOT] = prod.ua_ok[EDGE_BOT] && (n_bot >= lo_h) && (n_bot <= hi_h);
        ok[EDGE_RGT] = prod.ua_ok[EDGE_RGT] && (n_rgt >= lo_v) && (n_rgt <= hi_v);
        ok[EDGE_LFT] = prod.ua_ok[EDGE_LFT] && (n_lft >= lo_v) && (n_lft <= hi_v);

        div_next.hit   = |ok;
        div_next.horiz = 1'b1;
        div_next.fixed = prod.fix_top;
        div_next.d     = prod.dh;
        n_sel          = n_top;
        if (ok[EDGE_TOP])
        begin
            div_next.horiz = 1'b1;
        end
        else if (ok[EDGE_RGT])
        begin
            div_next.horiz = 1'b0;
            div_next.fixed = prod.fix_rgt;
            div_next.d     = prod.dv;
            n_sel          = n_rgt;
        end
        else if (ok[EDGE_BOT])
        begin
            div_next.fixed = prod.fix_bot;
            n_sel          = n_bot;
        end
        else if (ok[EDGE_LFT])
        begin
            div_next.horiz = 1'b0;
            div_next.fixed = prod.fix_lft;
            div_next.d     = prod.dv;
            n_sel          = n_lft;
        end
        div_next.neg = n_sel[PROD_BITS-1];
        div_next.mag = n_sel[PROD_BITS-1] ? PROD_BITS'(-n_sel) : PROD_BITS'(n_sel);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg <= div_next;
        end
    end

    assign out_vld = vld_reg;
    assign div     = div_reg;

endmodule

FILE: rtl/core/sri_div.sv
// Pipelined restoring divider (one quotient bit per stage) and result assembly.
module sri_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_vld,
    input  sri_pkg::sri_div_t    div,
    output logic                out_vld,
    output sri_pkg::sri_result_t result
);
    import sri_pkg::*;

    sri_dstage_t link     [COORD_BITS+1];
    logic        link_vld [COORD_BITS+1];

    assign link[0].hit   = div.hit;
    assign link[0].horiz = div.horiz;
    assign link[0].neg   = div.neg;
    assign link[0].fixed = div.fixed;
    assign link[0].rem   = div.mag;
    assign link[0].d     = div.d;
    assign link[0].q     = '0;
    assign link_vld[0]   = in_vld;

    for (genvar j = 0; j < COORD_BITS; j++)
    begin : g_stage
        localparam int K = COORD_BITS - 1 - j;
        sri_dstage_t stg_next, stg_reg;
        logic        vld_reg;
        logic [PROD_BITS-1:0] dsh;

        always_comb
        begin
            dsh      = PROD_BITS'(link[j].d) << K;
            stg_next = link[j];
            if (link[j].rem >= dsh)
            begin
                stg_next.rem  = link[j].rem - dsh;
                stg_next.q[K] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else if (en)
            begin
                vld_reg <= link_vld[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stg_reg <= stg_next;
            end
        end

        assign link[j+1]     = stg_reg;
        assign link_vld[j+1] = vld_reg;
    end

    sri_result_t res_next, res_reg;
    logic        res_vld_reg;
    logic [COORD_BITS-1:0] coord;
    sri_dstage_t last;

    always_comb
    begin
        last  = link[COORD_BITS];
        // truncation toward zero: divide magnitudes, then restore the sign
        coord = last.neg ? -last.q : last.q;
        res_next.hit   = last.hit;
        res_next.hit_x = '0;
        res_next.hit_y = '0;
        if (last.hit)
        begin
            res_next.hit_x = last.horiz ? coord : last.fixed;
            res_next.hit_y = last.horiz ? last.fixed : coord;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            res_vld_reg <= link_vld[COORD_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign out_vld = res_vld_reg;
    assign result  = res_reg;

endmodule
